// ===== sv/jbm_pkg.sv =====
package jbm_pkg;

    localparam int SEQ_W   = 32;
    localparam int STAMP_W = 32;
    localparam int BYTES_W = 10;
    localparam int SLOT_W  = 4;
    localparam int LEVEL_W = 5;

    localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 5'd5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // one input transfer
    typedef struct packed {
        logic               cmd;
        logic [SEQ_W-1:0]   seq_number;
        logic [STAMP_W-1:0] time_stamp;
        logic [BYTES_W-1:0] byte_count;
    } item_t;

    // one result transfer
    typedef struct packed {
        logic               delivered;
        logic [SLOT_W-1:0]  entry_slot;
        logic               overwrote;
        logic [SEQ_W-1:0]   got_seq;
        logic [STAMP_W-1:0] got_time;
        logic [BYTES_W-1:0] got_bytes;
        logic               waiting;
    } result_t;

    // stored slot descriptor
    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
        logic [BYTES_W-1:0] bytes;
    } desc_t;

    typedef logic [LEVEL_W-1:0] level_t;

endpackage

// ===== sv/jbm_stream_if.sv =====
interface jbm_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== sv/jbm_desc_mem.sv =====
module jbm_desc_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  jbm_pkg::desc_t        wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output jbm_pkg::desc_t        rd_data
);
    import jbm_pkg::*;

    desc_t desc_mem [DEPTH];
    desc_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= desc_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/jbm_ctrl.sv =====
module jbm_ctrl #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 640,
    parameter int IDX_W         = 4,
    parameter int CNT_W         = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  jbm_pkg::item_t        item,
    input  jbm_pkg::level_t       start_level,
    output logic                  idle,
    output logic                  done,
    input  logic                  taken,
    output jbm_pkg::result_t      result,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output jbm_pkg::desc_t        mem_wr_data,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  jbm_pkg::desc_t        mem_rd_data
);
    import jbm_pkg::*;

    localparam int CMP_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
    localparam logic [BYTES_W:0] PAYLOAD_LIM = (BYTES_W + 1)'(PAYLOAD_BYTES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             refill_reg, refill_next;
    logic             cmd_reg, cmd_next;
    desc_t            item_reg, item_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    desc_t            best_reg, best_next;
    result_t          res_reg, res_next;

    logic [IDX_W-1:0] cmp_idx;
    logic [SEQ_W-1:0] seq_diff;
    logic             older;
    logic [IDX_W-1:0] target;
    logic [BYTES_W-1:0] bytes_lim;

    // shared serial-number compare unit: slot under test against current best
    assign seq_diff = mem_rd_data.seq - best_reg.seq;
    assign older    = seq_diff[SEQ_W-1];
    assign cmp_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign target   = free_found_reg ? free_idx_reg : best_idx_reg;
    assign bytes_lim = ({1'b0, item.byte_count} > PAYLOAD_LIM) ?
                       PAYLOAD_LIM[BYTES_W-1:0] : item.byte_count;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        refill_next     = refill_reg;
        cmd_next        = cmd_reg;
        item_next       = item_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_next        = res_reg;
        mem_wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = item.cmd;
                    item_next.seq   = item.seq_number;
                    item_next.stamp = item.time_stamp;
                    item_next.bytes = bytes_lim;
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    res_next        = '0;
                    if (item.cmd == CMD_PUSH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (fill_reg == '0)
                    begin
                        // empty buffer: enter refill
                        refill_next      = 1'b1;
                        res_next.waiting = 1'b1;
                        state_next       = ST_DONE;
                    end
                    else if (refill_reg &&
                             (CMP_W'(fill_reg) < CMP_W'(start_level)))
                    begin
                        res_next.waiting = 1'b1;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        refill_next = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // read issued at cnt, compare works on the registered read data of slot cnt - 1
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0)
                begin
                    if (!valid_reg[cmp_idx])
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx;
                        end
                    end
                    else if (!best_found_reg || older)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = cmp_idx;
                        best_next       = mem_rd_data;
                    end
                end
                if (cnt_reg == CNT_W'(DEPTH))
                begin
                    state_next = (cmd_reg == CMD_PUSH) ? ST_PUSH : ST_POP;
                end
            end

            ST_PUSH:
            begin
                mem_wr_en          = 1'b1;
                valid_next[target] = 1'b1;
                if (free_found_reg)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                res_next.delivered  = 1'b1;
                res_next.entry_slot = SLOT_W'(target);
                res_next.overwrote  = !free_found_reg;
                res_next.waiting    = refill_reg;
                state_next          = ST_DONE;
            end

            ST_POP:
            begin
                valid_next[best_idx_reg] = 1'b0;
                fill_next           = fill_reg - CNT_W'(1);
                res_next.delivered  = 1'b1;
                res_next.entry_slot = SLOT_W'(best_idx_reg);
                res_next.got_seq    = best_reg.seq;
                res_next.got_time   = best_reg.stamp;
                res_next.got_bytes  = best_reg.bytes;
                res_next.waiting    = refill_reg;
                state_next          = ST_DONE;
            end

            ST_DONE:
            begin
                if (taken)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            fill_reg   <= '0;
            refill_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            fill_reg   <= fill_next;
            refill_reg <= refill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_reg        <= res_next;
    end

    assign idle        = (state_reg == ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign result      = res_reg;
    assign mem_wr_addr = target;
    assign mem_wr_data = item_reg;
    assign mem_rd_addr = cnt_reg[IDX_W-1:0];

endmodule

// ===== sv/jitter_buffer_manager_core.sv =====
// jitter buffer descriptor manager: a push stores sequence number, timestamp and
// byte count in the lowest free slot, or overwrites the slot holding the oldest
// sequence number (serial comparison, lowest index on a tie) when all DEPTH
// slots are full; a pop hands back the oldest valid slot and frees it, or
// returns nothing while the buffer is empty or refilling up to start_level.
// the reported slot index addresses an external payload memory. one item is
// handled at a time: a push, or a pop that returns an entry, runs a slot
// scan that reads the descriptor memory one slot per cycle through a single
// compare unit before its result is ready; a pop that returns nothing skips
// the scan and reports waiting.
// a result waits in an output register until the sink takes the transfer.
// start_level may be written through cfg whenever the block is idle; cfg is
// always ready. byte counts above PAYLOAD_BYTES are stored clamped.
module jitter_buffer_manager_core #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 640
) (
    input  logic               clk,
    input  logic               rst_n,
    jbm_stream_if.sink         in_ch,
    jbm_stream_if.source       out_ch,
    jbm_stream_if.sink         cfg
);
    import jbm_pkg::*;

    // slot index and fill count widths
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    level_t  start_level_reg;
    item_t   in_item;

    // controller status
    logic    ctrl_idle;
    logic    ctrl_done;
    result_t ctrl_result;
    logic    out_load;

    // descriptor memory ports
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    desc_t            mem_wr_data;
    logic [IDX_W-1:0] mem_rd_addr;
    desc_t            mem_rd_data;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    // config register, written on a cfg transfer
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg <= START_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            start_level_reg <= level_t'(cfg.payload);
        end
    end

    // input side: ready only while the sequencer is idle
    assign in_item     = item_t'(in_ch.payload);
    assign in_ch.ready = ctrl_idle;

    jbm_ctrl #(
        .DEPTH         (DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_ch.valid & ctrl_idle),
        .item        (in_item),
        .start_level (start_level_reg),
        .idle        (ctrl_idle),
        .done        (ctrl_done),
        .taken       (out_load),
        .result      (ctrl_result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    jbm_desc_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_desc_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register loads when empty or when its transfer completes
    assign out_load       = ctrl_done && (!out_valid_reg || out_ch.ready);
    assign out_valid_next = out_load || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= ctrl_result;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_data_reg;

endmodule
